// ----- rtl/onewire_master_timing_unit_assert.svh -----
// assertion macros for the one-wire master timing unit
`ifndef ONEWIRE_MASTER_TIMING_UNIT_ASSERT_SVH
`define ONEWIRE_MASTER_TIMING_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// antecedent and consequent in the same cycle
`define OWM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("owm assertion failed");
// consequent in the cycle after the antecedent
`define OWM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("owm assertion failed");
`else
`define OWM_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define OWM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- rtl/owm_pkg.sv -----
// types and constants shared by the one-wire master timing unit
package owm_pkg;

	localparam int CFG_W = 10;
	localparam int NUM_REGS = 8;
	localparam int CFG_IDX_W = 3;

	typedef logic [CFG_W-1:0] cfg_val_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	typedef logic [1:0] cmd_t;
	typedef logic [7:0] byte_t;

	localparam cmd_t CMD_NONE = 2'd0;
	localparam cmd_t CMD_RESET = 2'd1;
	localparam cmd_t CMD_WRITE = 2'd2;
	localparam cmd_t CMD_READ = 2'd3;

	localparam cfg_idx_t REG_RESET_LOW = 3'd0;
	localparam cfg_idx_t REG_RESET_RELEASE = 3'd1;
	localparam cfg_idx_t REG_PRES_WAIT = 3'd2;
	localparam cfg_idx_t REG_PRES_LOW = 3'd3;
	localparam cfg_idx_t REG_SHORT_PULSE = 3'd4;
	localparam cfg_idx_t REG_LONG_PULSE = 3'd5;
	localparam cfg_idx_t REG_SAMPLE_DELAY = 3'd6;
	localparam cfg_idx_t REG_READ_RECOVERY = 3'd7;

	localparam cfg_val_t RESET_LOW_INIT = 10'd750;
	localparam cfg_val_t RESET_RELEASE_INIT = 10'd15;
	localparam cfg_val_t PRES_WAIT_INIT = 10'd200;
	localparam cfg_val_t PRES_LOW_INIT = 10'd240;
	localparam cfg_val_t SHORT_PULSE_INIT = 10'd2;
	localparam cfg_val_t LONG_PULSE_INIT = 10'd60;
	localparam cfg_val_t SAMPLE_DELAY_INIT = 10'd12;
	localparam cfg_val_t READ_RECOVERY_INIT = 10'd50;

	typedef struct packed {
		cfg_val_t reset_low_time;
		cfg_val_t reset_release_time;
		cfg_val_t presence_wait_limit;
		cfg_val_t presence_low_limit;
		cfg_val_t short_pulse_time;
		cfg_val_t long_pulse_time;
		cfg_val_t sample_delay_time;
		cfg_val_t read_recovery_time;
	} owm_timing_t;

	typedef enum logic [3:0] {
		PH_IDLE = 4'd0,
		PH_RST_LOW = 4'd1,
		PH_RST_REL = 4'd2,
		PH_PRES_WAIT = 4'd3,
		PH_PRES_LOW = 4'd4,
		PH_WR_LOW = 4'd5,
		PH_WR_HIGH = 4'd6,
		PH_RD_LOW = 4'd7,
		PH_RD_DELAY = 4'd8,
		PH_RD_RECOV = 4'd9
	} phase_t;

endpackage

// ----- rtl/owm_cmd_if.sv -----
// tick channel: command, write byte and sampled line level
interface owm_cmd_if;
	import owm_pkg::*;

	logic valid;
	logic ready;
	cmd_t command;
	byte_t write_data;
	logic line_level;

	modport source (output valid, output command, output write_data, output line_level,
		input ready);
	modport sink (input valid, input command, input write_data, input line_level,
		output ready);
endinterface

// ----- rtl/owm_res_if.sv -----
// result channel: bus drive and command status per tick
interface owm_res_if;
	import owm_pkg::*;

	logic valid;
	logic ready;
	logic pull_low;
	logic busy_res;
	logic done_res;
	logic presence_fail;
	byte_t read_byte;

	modport source (output valid, output pull_low, output busy_res, output done_res,
		output presence_fail, output read_byte, input ready);
	modport sink (input valid, input pull_low, input busy_res, input done_res,
		input presence_fail, input read_byte, output ready);
endinterface

// ----- rtl/owm_cfg_regs.sv -----
// timing register file with write port
module owm_cfg_regs (
	input logic clk,
	input logic arst_n,
	input logic cfg_wr_en,
	input owm_pkg::cfg_idx_t cfg_index,
	input owm_pkg::cfg_val_t cfg_wdata,
	output owm_pkg::owm_timing_t timing
);
	import owm_pkg::*;

	owm_timing_t timing_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timing_q.reset_low_time <= RESET_LOW_INIT;
			timing_q.reset_release_time <= RESET_RELEASE_INIT;
			timing_q.presence_wait_limit <= PRES_WAIT_INIT;
			timing_q.presence_low_limit <= PRES_LOW_INIT;
			timing_q.short_pulse_time <= SHORT_PULSE_INIT;
			timing_q.long_pulse_time <= LONG_PULSE_INIT;
			timing_q.sample_delay_time <= SAMPLE_DELAY_INIT;
			timing_q.read_recovery_time <= READ_RECOVERY_INIT;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_RESET_LOW: timing_q.reset_low_time <= cfg_wdata;
				REG_RESET_RELEASE: timing_q.reset_release_time <= cfg_wdata;
				REG_PRES_WAIT: timing_q.presence_wait_limit <= cfg_wdata;
				REG_PRES_LOW: timing_q.presence_low_limit <= cfg_wdata;
				REG_SHORT_PULSE: timing_q.short_pulse_time <= cfg_wdata;
				REG_LONG_PULSE: timing_q.long_pulse_time <= cfg_wdata;
				REG_SAMPLE_DELAY: timing_q.sample_delay_time <= cfg_wdata;
				REG_READ_RECOVERY: timing_q.read_recovery_time <= cfg_wdata;
				default: timing_q <= timing_q;
			endcase
		end
	end

	assign timing = timing_q;
endmodule

// ----- rtl/onewire_master_timing_unit.sv -----
// One-wire bus master timing unit. Each beat on cmd_ch is one microsecond tick carrying the
// sampled line level and an optional command (reset with presence check, write byte, read
// byte), taken only while the master is idle. Every tick beat yields exactly one result beat
// on res_ch with the bus drive and status. One beat is accepted per clock cycle while res_ch
// is not stalled; an accepted tick waits in the input register and its result is loaded into
// the result register, around the phase sequencer and its one shared phase timer. A stalled
// result holds the tick in the input register, and cmd_ch.ready drops only while both are full.
// The user must write timing registers through the cfg port only while no tick is in flight;
// the block itself does not enforce this.
module onewire_master_timing_unit #(
	parameter int COUNTER_BITS = 10
) (
	input logic clk,
	input logic arst_n,
	owm_cmd_if.sink cmd_ch,
	owm_res_if.source res_ch,
	input logic cfg_wr_en,
	input owm_pkg::cfg_idx_t cfg_index,
	input owm_pkg::cfg_val_t cfg_wdata
);
	import owm_pkg::*;

	`include "onewire_master_timing_unit_assert.svh"

	localparam int LW = ((COUNTER_BITS > CFG_W) ? COUNTER_BITS : CFG_W) + 1;
	localparam logic [LW-1:0] CNT_MAX = LW'((2 ** COUNTER_BITS) - 1);

	owm_timing_t timing;

	owm_cfg_regs u_cfg_regs (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.timing(timing)
	);

	// input register
	logic valid_s1;
	cmd_t command_s1;
	byte_t write_data_s1;
	logic line_level_s1;

	// result register
	logic res_valid_q;
	logic pull_low_q, busy_q, done_q, pfail_q;
	byte_t read_byte_q;

	// sequencer state
	phase_t phase_q;
	logic [COUNTER_BITS-1:0] time_count_q;
	logic [2:0] bit_index_q;
	byte_t shift_byte_q;
	logic fail_flag_q;

	logic adv;
	assign adv = valid_s1 && (!res_valid_q || res_ch.ready);
	assign cmd_ch.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_ch.ready) begin
			valid_s1 <= cmd_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_ch.ready && cmd_ch.valid) begin
			command_s1 <= cmd_ch.command;
			write_data_s1 <= cmd_ch.write_data;
			line_level_s1 <= cmd_ch.line_level;
		end
	end

	// next-state logic for one tick
	phase_t ph, ph_nx;
	logic [COUNTER_BITS-1:0] tc, tc_nx, tc_inc;
	logic [2:0] bi, bi_nx;
	byte_t sb, sb_nx;
	logic fail, fail_nx;
	logic cur_bit;
	cfg_val_t sel_reg;
	logic [LW-1:0] len, tc_plus;
	logic last;
	logic pull, busy, done, pfail;
	byte_t rbyte;

	always_comb begin
		ph = phase_q;
		tc = time_count_q;
		bi = bit_index_q;
		sb = shift_byte_q;
		fail = fail_flag_q;
		if (phase_q == PH_IDLE && command_s1 != CMD_NONE) begin
			tc = '0;
			bi = '0;
			fail = 1'b0;
			case (command_s1)
				CMD_RESET: begin
					ph = PH_RST_LOW;
					sb = '0;
				end
				CMD_WRITE: begin
					ph = PH_WR_LOW;
					sb = write_data_s1;
				end
				default: begin
					ph = PH_RD_LOW;
					sb = '0;
				end
			endcase
		end
		cur_bit = sb[0];

		case (ph)
			PH_RST_LOW: sel_reg = timing.reset_low_time;
			PH_RST_REL: sel_reg = timing.reset_release_time;
			PH_PRES_WAIT: sel_reg = timing.presence_wait_limit;
			PH_PRES_LOW: sel_reg = timing.presence_low_limit;
			PH_WR_LOW: sel_reg = cur_bit ? timing.short_pulse_time : timing.long_pulse_time;
			PH_WR_HIGH: sel_reg = cur_bit ? timing.long_pulse_time : timing.short_pulse_time;
			PH_RD_LOW: sel_reg = timing.short_pulse_time;
			PH_RD_DELAY: sel_reg = timing.sample_delay_time;
			PH_RD_RECOV: sel_reg = timing.read_recovery_time;
			default: sel_reg = timing.reset_low_time;
		endcase

		// zero lasts one tick, long times clip to the counter maximum
		if (sel_reg == '0) begin
			len = LW'(1);
		end else if (LW'(sel_reg) > CNT_MAX) begin
			len = CNT_MAX;
		end else begin
			len = LW'(sel_reg);
		end
		tc_plus = LW'(tc) + LW'(1);
		last = (tc_plus >= len);
		tc_inc = last ? '0 : tc_plus[COUNTER_BITS-1:0];

		ph_nx = ph;
		tc_nx = tc;
		bi_nx = bi;
		sb_nx = sb;
		fail_nx = fail;
		pull = 1'b0;
		busy = 1'b1;
		done = 1'b0;
		pfail = 1'b0;
		rbyte = '0;

		case (ph)
			PH_RST_LOW: begin
				pull = 1'b1;
				tc_nx = tc_inc;
				if (last) ph_nx = PH_RST_REL;
			end
			PH_RST_REL: begin
				tc_nx = tc_inc;
				if (last) ph_nx = PH_PRES_WAIT;
			end
			PH_PRES_WAIT: begin
				if (!line_level_s1) begin
					tc_nx = '0;
					ph_nx = PH_PRES_LOW;
				end else begin
					tc_nx = tc_inc;
					if (last) begin
						fail_nx = 1'b1;
						done = 1'b1;
					end
				end
			end
			PH_PRES_LOW: begin
				if (line_level_s1) begin
					tc_nx = '0;
					fail_nx = 1'b0;
					done = 1'b1;
				end else begin
					tc_nx = tc_inc;
					if (last) begin
						fail_nx = 1'b1;
						done = 1'b1;
					end
				end
			end
			PH_WR_LOW: begin
				pull = 1'b1;
				tc_nx = tc_inc;
				if (last) ph_nx = PH_WR_HIGH;
			end
			PH_WR_HIGH: begin
				tc_nx = tc_inc;
				if (last) begin
					sb_nx = {1'b0, sb[7:1]};
					if (bi == 3'd7) begin
						done = 1'b1;
					end else begin
						bi_nx = bi + 3'd1;
						ph_nx = PH_WR_LOW;
					end
				end
			end
			PH_RD_LOW: begin
				pull = 1'b1;
				tc_nx = tc_inc;
				if (last) ph_nx = PH_RD_DELAY;
			end
			PH_RD_DELAY: begin
				tc_nx = tc_inc;
				// sample on the last tick of the delay, lsb first
				if (last) begin
					sb_nx = {line_level_s1, sb[7:1]};
					ph_nx = PH_RD_RECOV;
				end
			end
			PH_RD_RECOV: begin
				tc_nx = tc_inc;
				if (last) begin
					if (bi == 3'd7) begin
						done = 1'b1;
						rbyte = sb;
					end else begin
						bi_nx = bi + 3'd1;
						ph_nx = PH_RD_LOW;
					end
				end
			end
			default: begin
				busy = 1'b0;
			end
		endcase

		if (done) begin
			if (ph == PH_PRES_WAIT || ph == PH_PRES_LOW) pfail = fail_nx;
			ph_nx = PH_IDLE;
			tc_nx = '0;
			bi_nx = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			time_count_q <= '0;
			bit_index_q <= '0;
			shift_byte_q <= '0;
			fail_flag_q <= 1'b0;
		end else if (adv) begin
			phase_q <= ph_nx;
			time_count_q <= tc_nx;
			bit_index_q <= bi_nx;
			shift_byte_q <= sb_nx;
			fail_flag_q <= fail_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= 1'b1;
		end else if (res_ch.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pull_low_q <= pull;
			busy_q <= busy;
			done_q <= done;
			pfail_q <= pfail;
			read_byte_q <= rbyte;
		end
	end

	assign res_ch.valid = res_valid_q;
	assign res_ch.pull_low = pull_low_q;
	assign res_ch.busy_res = busy_q;
	assign res_ch.done_res = done_q;
	assign res_ch.presence_fail = pfail_q;
	assign res_ch.read_byte = read_byte_q;

	`OWM_ASSERT_SAME(a_done_busy, clk, arst_n, res_valid_q && done_q, busy_q)
	`OWM_ASSERT_SAME(a_pfail_done, clk, arst_n, res_valid_q && pfail_q, done_q && !pull_low_q)
	`OWM_ASSERT_NEXT(a_adv_result, clk, arst_n, adv, res_valid_q)
	`OWM_ASSERT_NEXT(a_done_idle, clk, arst_n, adv && done, phase_q == PH_IDLE && bit_index_q == 3'd0)
endmodule
